/* src/i2c_bus_byte_monitor_top_defines.svh */
// Assertion macros shared by the I2C bus byte monitor RTL.
`ifndef I2C_BUS_BYTE_MONITOR_TOP_DEFINES_SVH
`define I2C_BUS_BYTE_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2CMON_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2CMON_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2cmon_pkg.sv */
// Types, constants and helper functions of the I2C bus byte monitor.
`default_nettype none

package i2cmon_pkg;

  localparam int unsigned CHANNELS_DEF     = 3;
  localparam int unsigned BUFFER_BYTES_DEF = 256;

  localparam int unsigned CH_W       = 2;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned BIT_CNT_W  = 4;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Register select taken from paddr[2].
  typedef enum logic {
    REG_DATA_CH  = 1'b0,
    REG_CLOCK_CH = 1'b1
  } reg_sel_e;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e      kind;
    logic [7:0]       data_byte;
    logic             nack;
    logic             kept;
    logic [CNT_W-1:0] txn_total;
    logic [CNT_W-1:0] byte_total;
    logic [CNT_W-1:0] nack_total;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

/* src/i2c_bus_byte_monitor_top.sv */
// I2C bus byte monitor: decodes START, STOP and bytes from captured samples.
// A result is registered into the output register, or into the skid entry while that is held, before m_axis.
// Throughput: one sample per clock while s_axis_tready is high; all decoding is a single pass of logic
// between the bus state registers and a two-entry output buffer (register plus skid).
// s_axis_tready drops only while both output entries hold unread results.
// Reset clears the bus state, counters and output buffer; channels return to 0 and 1.
`default_nettype none

`include "i2c_bus_byte_monitor_top_defines.svh"

module i2c_bus_byte_monitor_top
  import i2cmon_pkg::*;
#(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int unsigned IN_TDATA_W  = ((CHANNELS + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready,
  // Sample stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_bits, zero padding
  input  wire logic                   s_axis_tuser,  // capture_start
  // Event stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // data_byte, nack, kept,
                                                     // transaction_total, byte_total,
                                                     // nack_total, zero padding
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser   // event_kind
);

  localparam int unsigned LOW_CH = (CHANNELS < 4) ? CHANNELS : 4;
  localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);

  // Configuration registers.
  logic [CH_W-1:0] data_ch_q, clk_ch_q;
  logic            cfg_wr;
  reg_sel_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_sel_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_ch_q <= CH_W'(0);
      clk_ch_q  <= CH_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DATA_CH:  data_ch_q <= pwdata[CH_W-1:0];
        REG_CLOCK_CH: clk_ch_q  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DATA_CH:  prdata = {{(APB_DATA_W-CH_W){1'b0}}, data_ch_q};
      REG_CLOCK_CH: prdata = {{(APB_DATA_W-CH_W){1'b0}}, clk_ch_q};
      default:      prdata = '0;
    endcase
  end

  // Channel selection: channels at or above CHANNELS read as low.
  logic [3:0] samp4;
  logic       data_ok, clk_ok, chan_ok, sda, scl;

  always_comb begin
    samp4 = '0;
    for (int i = 0; i < LOW_CH; i++) begin
      samp4[i] = s_axis_tdata[i];
    end
  end

  assign data_ok = int'(data_ch_q) < CHANNELS;
  assign clk_ok  = int'(clk_ch_q) < CHANNELS;
  assign chan_ok = data_ok & clk_ok & (data_ch_q != clk_ch_q);
  assign sda     = data_ok & samp4[data_ch_q];
  assign scl     = clk_ok & samp4[clk_ch_q];

  // Bus state.
  logic                 primed_q, primed_d;
  logic                 last_sda_q, last_sda_d;
  logic                 last_scl_q, last_scl_d;
  logic                 in_txn_q, in_txn_d;
  logic [BIT_CNT_W-1:0] bits_q, bits_d;
  logic [7:0]           shift_q, shift_d;
  logic [CNT_W-1:0]     txn_cnt_q, txn_cnt_d;
  logic [CNT_W-1:0]     byte_cnt_q, byte_cnt_d;
  logic [CNT_W-1:0]     nack_cnt_q, nack_cnt_d;

  logic    in_fire, has_res;
  result_t res;

  assign in_fire = s_axis_tvalid & s_axis_tready;

  always_comb begin
    primed_d   = primed_q;
    last_sda_d = last_sda_q;
    last_scl_d = last_scl_q;
    in_txn_d   = in_txn_q;
    bits_d     = bits_q;
    shift_d    = shift_q;
    txn_cnt_d  = txn_cnt_q;
    byte_cnt_d = byte_cnt_q;
    nack_cnt_d = nack_cnt_q;
    has_res    = 1'b0;
    res.kind       = EV_BYTE;
    res.data_byte  = 8'd0;
    res.nack       = 1'b0;
    res.kept       = 1'b0;

    if (in_fire) begin
      last_sda_d = sda;
      last_scl_d = scl;
      priority if (s_axis_tuser) begin
        primed_d   = 1'b1;
        in_txn_d   = 1'b0;
        bits_d     = '0;
        shift_d    = '0;
        txn_cnt_d  = '0;
        byte_cnt_d = '0;
        nack_cnt_d = '0;
      end else if (!primed_q) begin
        primed_d = 1'b1;
      end else if (chan_ok) begin
        priority if (last_sda_q && !sda && scl) begin
          in_txn_d  = 1'b1;
          bits_d    = '0;
          shift_d   = '0;
          txn_cnt_d = sat_inc(txn_cnt_q);
          has_res   = 1'b1;
          res.kind  = EV_START;
        end else if (!last_sda_q && sda && scl) begin
          in_txn_d = 1'b0;
          bits_d   = '0;
          has_res  = 1'b1;
          res.kind = EV_STOP;
        end else if (in_txn_q && !last_scl_q && scl) begin
          if (bits_q < BITS_PER_BYTE) begin
            shift_d = {shift_q[6:0], sda};
            bits_d  = bits_q + BIT_CNT_W'(1);
          end else begin
            // Ninth clock: the acknowledge bit closes the byte.
            byte_cnt_d    = sat_inc(byte_cnt_q);
            nack_cnt_d    = sda ? sat_inc(nack_cnt_q) : nack_cnt_q;
            bits_d        = '0;
            shift_d       = '0;
            has_res       = 1'b1;
            res.kind      = EV_BYTE;
            res.data_byte = shift_q;
            res.nack      = sda;
            res.kept      = byte_cnt_q < BUF_LIMIT;
          end
        end else begin
          // No bus condition on this sample.
        end
      end else begin
        // Channel setup is unusable; only the levels are tracked.
      end
    end
    res.txn_total  = txn_cnt_d;
    res.byte_total = byte_cnt_d;
    res.nack_total = nack_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      last_sda_q <= 1'b0;
      last_scl_q <= 1'b0;
      in_txn_q   <= 1'b0;
      bits_q     <= '0;
      shift_q    <= '0;
      txn_cnt_q  <= '0;
      byte_cnt_q <= '0;
      nack_cnt_q <= '0;
    end else begin
      primed_q   <= primed_d;
      last_sda_q <= last_sda_d;
      last_scl_q <= last_scl_d;
      in_txn_q   <= in_txn_d;
      bits_q     <= bits_d;
      shift_q    <= shift_d;
      txn_cnt_q  <= txn_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      nack_cnt_q <= nack_cnt_d;
    end
  end

  // Output register with a skid entry behind it.
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    out_fire, push;

  assign out_fire = out_vld_q & m_axis_tready;
  assign push     = in_fire & has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !out_fire) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'b0, out_q.nack_total, out_q.byte_total, out_q.txn_total,
                          out_q.kept, out_q.nack, out_q.data_byte};

  `I2CMON_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry without output entry")
  `I2CMON_ASSERT_IMP(a_nack_le_byte, 1'b1, nack_cnt_q <= byte_cnt_q, "more NACKs than bytes")
  `I2CMON_ASSERT_IMP(a_bits_range, 1'b1, bits_q <= BITS_PER_BYTE, "bit count past acknowledge")
  `I2CMON_ASSERT_IMP(a_idle_no_bits, !in_txn_q, bits_q == '0, "bits counted outside a transaction")
  `I2CMON_ASSERT_NXT(a_capture_clears, in_fire && s_axis_tuser,
                     txn_cnt_q == '0 && byte_cnt_q == '0 && !in_txn_q,
                     "capture start did not clear the counts")

endmodule

`default_nettype wire
